// ===== sv/atsg_pkg.sv =====
// Package for the alarm tone sweep generator: payload types, register map, reset values.
package atsg_pkg;

    // Alarm mode codes
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_SIREN = 2'd1;
    localparam logic [1:0] MODE_FIRE  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_SIREN_LOW   = 3'd0;
    localparam logic [2:0] REG_SIREN_HIGH  = 3'd1;
    localparam logic [2:0] REG_SIREN_STEP  = 3'd2;
    localparam logic [2:0] REG_RISE_START  = 3'd3;
    localparam logic [2:0] REG_RISE_TOP    = 3'd4;
    localparam logic [2:0] REG_FALL_START  = 3'd5;
    localparam logic [2:0] REG_FALL_BOTTOM = 3'd6;

    localparam int FREQ_W  = 16;
    localparam int STEP_W  = 10;
    localparam int INDEX_W = 3;

    // Reset values
    localparam logic [FREQ_W-1:0] SIREN_LOW_RST   = 16'd600;
    localparam logic [FREQ_W-1:0] SIREN_HIGH_RST  = 16'd1400;
    localparam logic [STEP_W-1:0] SIREN_STEP_RST  = 10'd10;
    localparam logic [FREQ_W-1:0] RISE_START_RST  = 16'd650;
    localparam logic [FREQ_W-1:0] RISE_TOP_RST    = 16'd750;
    localparam logic [FREQ_W-1:0] FALL_START_RST  = 16'd550;
    localparam logic [FREQ_W-1:0] FALL_BOTTOM_RST = 16'd450;

    typedef struct packed {
        logic [1:0] mode;
        logic       tick;
    } atsg_in_t;

    typedef struct packed {
        logic [FREQ_W-1:0] tone_freq;
        logic              freq_updated;
    } atsg_out_t;

    typedef struct packed {
        logic [FREQ_W-1:0] siren_low_freq;
        logic [FREQ_W-1:0] siren_high_freq;
        logic [STEP_W-1:0] siren_step;
        logic [FREQ_W-1:0] fire_rise_start;
        logic [FREQ_W-1:0] fire_rise_top;
        logic [FREQ_W-1:0] fire_fall_start;
        logic [FREQ_W-1:0] fire_fall_bottom;
    } atsg_cfg_t;

endpackage

// ===== sv/atsg_cfg.sv =====
// Configuration register file for the alarm tone sweep generator.
module atsg_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [atsg_pkg::INDEX_W-1:0]  wr_index,
    input  logic [atsg_pkg::FREQ_W-1:0]   wr_data,
    output atsg_pkg::atsg_cfg_t           cfg
);

    atsg_pkg::atsg_cfg_t cfg_reg;

    // Register writes; unknown index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.siren_low_freq   <= atsg_pkg::SIREN_LOW_RST;
            cfg_reg.siren_high_freq  <= atsg_pkg::SIREN_HIGH_RST;
            cfg_reg.siren_step       <= atsg_pkg::SIREN_STEP_RST;
            cfg_reg.fire_rise_start  <= atsg_pkg::RISE_START_RST;
            cfg_reg.fire_rise_top    <= atsg_pkg::RISE_TOP_RST;
            cfg_reg.fire_fall_start  <= atsg_pkg::FALL_START_RST;
            cfg_reg.fire_fall_bottom <= atsg_pkg::FALL_BOTTOM_RST;
        end else if (wr_en) begin
            case (wr_index)
                atsg_pkg::REG_SIREN_LOW:   cfg_reg.siren_low_freq   <= wr_data;
                atsg_pkg::REG_SIREN_HIGH:  cfg_reg.siren_high_freq  <= wr_data;
                atsg_pkg::REG_SIREN_STEP:
                    cfg_reg.siren_step <= wr_data[atsg_pkg::STEP_W-1:0];
                atsg_pkg::REG_RISE_START:  cfg_reg.fire_rise_start  <= wr_data;
                atsg_pkg::REG_RISE_TOP:    cfg_reg.fire_rise_top    <= wr_data;
                atsg_pkg::REG_FALL_START:  cfg_reg.fire_fall_start  <= wr_data;
                atsg_pkg::REG_FALL_BOTTOM: cfg_reg.fire_fall_bottom <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/atsg_core.sv =====
// Sweep state and next-frequency logic for the alarm tone sweep generator.
module atsg_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  atsg_pkg::atsg_in_t   item,
    input  atsg_pkg::atsg_cfg_t  cfg,
    output atsg_pkg::atsg_out_t  result
);

    localparam int W = atsg_pkg::FREQ_W;

    logic [W-1:0] siren_freq_reg, siren_freq_next;
    logic         siren_rising_reg, siren_rising_next;
    logic [W-1:0] rise_freq_reg, rise_freq_next;
    logic [W-1:0] fall_freq_reg, fall_freq_next;
    logic         falling_phase_reg, falling_phase_next;
    logic [W-1:0] held_freq_reg, held_freq_next;

    logic [W:0]   siren_sum;
    logic [W-1:0] siren_up, siren_down, rise_inc, fall_dec;
    logic [W-1:0] step_ext;

    // Saturating arithmetic
    always_comb begin
        step_ext  = {{(W-atsg_pkg::STEP_W){1'b0}}, cfg.siren_step};
        siren_sum = {1'b0, siren_freq_reg} + {1'b0, step_ext};
        siren_up  = siren_sum[W] ? {W{1'b1}} : siren_sum[W-1:0];
        siren_down = (siren_freq_reg > step_ext) ? (siren_freq_reg - step_ext) : '0;
        rise_inc  = (rise_freq_reg == {W{1'b1}}) ? rise_freq_reg : (rise_freq_reg + 1'b1);
        fall_dec  = (fall_freq_reg == '0) ? fall_freq_reg : (fall_freq_reg - 1'b1);
    end

    // Next state and result for the current item
    always_comb begin
        siren_freq_next    = siren_freq_reg;
        siren_rising_next  = siren_rising_reg;
        rise_freq_next     = rise_freq_reg;
        fall_freq_next     = fall_freq_reg;
        falling_phase_next = falling_phase_reg;
        held_freq_next     = held_freq_reg;
        result.freq_updated = 1'b0;
        case (item.mode)
            atsg_pkg::MODE_SIREN: begin
                if (item.tick) begin
                    result.freq_updated = 1'b1;
                    if (siren_rising_reg) begin
                        siren_freq_next = siren_up;
                        if (siren_up >= cfg.siren_high_freq) siren_rising_next = 1'b0;
                    end else begin
                        siren_freq_next = siren_down;
                        if (siren_down <= cfg.siren_low_freq) siren_rising_next = 1'b1;
                    end
                    held_freq_next = siren_freq_next;
                end
            end
            atsg_pkg::MODE_FIRE: begin
                if (item.tick) begin
                    result.freq_updated = 1'b1;
                    if (!falling_phase_reg) begin
                        if (rise_inc >= cfg.fire_rise_top) begin
                            falling_phase_next = 1'b1;
                            rise_freq_next     = cfg.fire_rise_start;
                            held_freq_next     = fall_freq_reg;
                        end else begin
                            rise_freq_next = rise_inc;
                            held_freq_next = rise_inc;
                        end
                    end else begin
                        if (fall_dec <= cfg.fire_fall_bottom) begin
                            falling_phase_next = 1'b0;
                            fall_freq_next     = cfg.fire_fall_start;
                            held_freq_next     = rise_freq_reg;
                        end else begin
                            fall_freq_next = fall_dec;
                            held_freq_next = fall_dec;
                        end
                    end
                end
            end
            default: begin
                // off and unused code: silence every item
                held_freq_next      = '0;
                result.freq_updated = 1'b1;
            end
        endcase
        result.tone_freq = held_freq_next;
    end

    // State registers, updated once per transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            siren_freq_reg    <= '0;
            siren_rising_reg  <= 1'b1;
            rise_freq_reg     <= atsg_pkg::RISE_START_RST;
            fall_freq_reg     <= atsg_pkg::FALL_START_RST;
            falling_phase_reg <= 1'b0;
            held_freq_reg     <= '0;
        end else if (advance) begin
            siren_freq_reg    <= siren_freq_next;
            siren_rising_reg  <= siren_rising_next;
            rise_freq_reg     <= rise_freq_next;
            fall_freq_reg     <= fall_freq_next;
            falling_phase_reg <= falling_phase_next;
            held_freq_reg     <= held_freq_next;
        end
    end

    // Off mode leaves held frequency at zero
    a_off_clears_held: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (item.mode == atsg_pkg::MODE_OFF) |=> held_freq_reg == '0)
        else $error("held frequency not cleared by off mode");

    // Without a tick the held frequency is repeated
    a_no_tick_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        ((item.mode == atsg_pkg::MODE_SIREN) || (item.mode == atsg_pkg::MODE_FIRE))
        && !item.tick |-> (result.tone_freq == held_freq_reg) && !result.freq_updated)
        else $error("frequency changed without a tick");

    // Off mode leaves the sweep state untouched
    a_off_keeps_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (item.mode == atsg_pkg::MODE_OFF)
        |=> $stable(siren_freq_reg) && $stable(rise_freq_reg) && $stable(fall_freq_reg)
            && $stable(falling_phase_reg) && $stable(siren_rising_reg))
        else $error("sweep state moved in off mode");

endmodule

// ===== sv/alarm_tone_sweep_generator_top.sv =====
// Top level of the alarm tone sweep generator: input and result registers around the core.
// One item is accepted per cycle while the result register is not stalled; each result
// passes through the input register, then the result register, before it is presented.
// The sweep state updates as an item moves from the input register into the result
// register, so consecutive items chain without gaps.
// Configuration writes are taken every cycle and apply to items that reach the core after
// the write; write only while no items are in flight. Index 7 is ignored.
module alarm_tone_sweep_generator_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  atsg_pkg::atsg_in_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output atsg_pkg::atsg_out_t           m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [atsg_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [atsg_pkg::FREQ_W-1:0]   cfg_data
);

    atsg_pkg::atsg_cfg_t cfg;
    atsg_pkg::atsg_in_t  in_reg;
    atsg_pkg::atsg_out_t out_reg, core_result;
    logic in_valid_reg, out_valid_reg;
    logic out_free, advance;

    assign cfg_ready = 1'b1;

    atsg_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Pipeline flow control
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;

    atsg_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // A transfer in always fills the input register
    a_in_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> in_valid_reg)
        else $error("accepted item lost at input register");

    // A waiting item is never overwritten while the result is stalled
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_reg))
        else $error("stalled item changed");

    // Core advances only into a free result register
    a_adv_free: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result missing after advance");

endmodule
